[design/rcbc_pkg.sv]
// rcbc_pkg: shared constants and types for the RSA/CBC block decryptor.
// No dependencies; compiled first.
package rcbc_pkg;

  // Default value width (fields, registers, residues)
  localparam int VALUE_BITS_DEF = 31;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EXPONENT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEED     = 2'd2;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LOOP,
    ST_MUL_ACC,
    ST_MUL_SQR,
    ST_FINISH
  } rcbc_state_t;

  // Status of the bit-serial modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

[design/rcbc_if.sv]
// rcbc_if: request and result channel interfaces (valid/ready).
// Depends on rcbc_pkg for the default value width.
interface rcbc_in_if import rcbc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] cipher_block;
  logic                  message_start;

  modport source (output valid, cipher_block, message_start, input ready);
  modport sink   (input valid, cipher_block, message_start, output ready);
endinterface

interface rcbc_out_if import rcbc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] plain_value;

  modport source (output valid, plain_value, input ready);
  modport sink   (input valid, plain_value, output ready);
endinterface

[design/rcbc_modmul.sv]
// rcbc_modmul: bit-serial interleaved modular multiplier, a*b mod m.
// One multiplier bit per cycle, MSB first. Depends on rcbc_pkg.
module rcbc_modmul import rcbc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] a,
  input  logic [VALUE_BITS-1:0] b,
  input  logic [VALUE_BITS-1:0] m,
  output logic [VALUE_BITS-1:0] product,
  output mm_status_t            status
);

  localparam int CW = $clog2(VALUE_BITS);

  logic                  busy_r;
  logic                  done_r;
  logic [CW-1:0]         cnt_r;
  logic [VALUE_BITS-1:0] a_r;
  logic [VALUE_BITS-1:0] b_r;
  logic [VALUE_BITS-1:0] m_r;
  logic [VALUE_BITS-1:0] acc_r;
  logic [VALUE_BITS-1:0] acc_nxt;

  logic [VALUE_BITS:0] m_ext;
  logic [VALUE_BITS:0] dbl;
  logic [VALUE_BITS:0] d1;
  logic [VALUE_BITS:0] sum;
  logic [VALUE_BITS:0] d2;
  logic                last;

  // acc < m holds throughout: 2*acc and acc+b each need one subtract
  always_comb begin
    m_ext   = {1'b0, m_r};
    dbl     = {acc_r, 1'b0};
    d1      = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum     = d1 + (a_r[VALUE_BITS-1] ? {1'b0, b_r} : '0);
    d2      = (sum >= m_ext) ? sum - m_ext : sum;
    acc_nxt = d2[VALUE_BITS-1:0];
    last    = busy_r && (cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      m_r   <= m;
      acc_r <= '0;
      cnt_r <= CW'(VALUE_BITS - 1);
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      a_r   <= {a_r[VALUE_BITS-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign product     = acc_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (acc_r < m_r))
    else $error("modmul partial product not below modulus");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("modmul done while still busy");

endmodule

[design/rsa_cbc_block_decrypt.sv]
// rsa_cbc_block_decrypt: RSA modular exponentiation with CBC chaining.
// Depends on rcbc_pkg, rcbc_if (rcbc_in_if, rcbc_out_if) and rcbc_modmul.
//
// Usage:
//  - in_req carries one ciphertext block per request (cipher_block) and a
//    message_start flag; out_rsp returns one plain_value per request.
//  - cfg_we/cfg_index/cfg_wdata write private_exponent (0), modulus (1) and
//    chain_seed (2); other indexes are ignored. Write only while idle.
//  - A request is reduced mod modulus bit-serially, then raised to the
//    exponent by right-to-left square-and-multiply on one shared
//    bit-serial modular multiplier. A modulus below two skips all
//    arithmetic (decrypted value 0).
//  - One request in flight at a time; in_req.ready is high only when idle,
//    so the next request is taken only once the current one has left FINISH.
//    The result sits in an output register, so the next request can be
//    taken while out_rsp waits; if it is still waiting when the next result
//    is done, the sequencer holds in FINISH until the receiver takes it.
//  - Reset (synchronous, rst_n low): sequencer idle, no result pending,
//    exponent 0, modulus 2, seed 0, chain value 0.
module rsa_cbc_block_decrypt import rcbc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  rcbc_in_if.sink                 in_req,
  rcbc_out_if.source              out_rsp,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [VALUE_BITS-1:0]   cfg_wdata
);

  localparam int CW = $clog2(VALUE_BITS);

  // Configuration registers
  logic [VALUE_BITS-1:0] exponent_r;
  logic [VALUE_BITS-1:0] modulus_r;
  logic [VALUE_BITS-1:0] seed_r;

  // Sequencer and datapath
  rcbc_state_t           state_r, state_nxt;
  logic [VALUE_BITS-1:0] chain_value_r, chain_value_nxt; // last raw block
  logic [VALUE_BITS-1:0] chain_sel_r, chain_sel_nxt;     // chain for this block
  logic [VALUE_BITS-1:0] blk_r, blk_nxt;                 // block, shifted MSB out
  logic [VALUE_BITS-1:0] red_r, red_nxt;                 // partial remainder
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] exp_r, exp_nxt;
  logic [VALUE_BITS-1:0] base_r, base_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] plain_r, plain_nxt;

  logic                  in_take;
  logic [VALUE_BITS:0]   red_t;
  logic [VALUE_BITS:0]   mod_ext;
  logic                  mm_start;
  logic                  mm_a_acc;
  logic [VALUE_BITS-1:0] mm_a;
  logic [VALUE_BITS-1:0] mm_product;
  mm_status_t            mm_stat;

  rcbc_modmul #(.VALUE_BITS(VALUE_BITS)) u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .a       (mm_a),
    .b       (base_r),
    .m       (modulus_r),
    .product (mm_product),
    .status  (mm_stat)
  );

  assign mm_a = mm_a_acc ? acc_r : base_r;

  // Config write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= '0;
      modulus_r  <= VALUE_BITS'(2);
      seed_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPONENT: exponent_r <= cfg_wdata;
        CFG_MODULUS:  modulus_r  <= cfg_wdata;
        CFG_SEED:     seed_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_req.ready      = (state_r == ST_IDLE);
  assign in_take           = in_req.valid && in_req.ready;
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.plain_value = plain_r;

  // Restoring remainder step: shift in the next block bit, subtract once
  assign mod_ext = {1'b0, modulus_r};
  assign red_t   = {red_r, blk_r[VALUE_BITS-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      chain_value_r <= '0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      chain_value_r <= chain_value_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chain_sel_r <= chain_sel_nxt;
    blk_r       <= blk_nxt;
    red_r       <= red_nxt;
    cnt_r       <= cnt_nxt;
    exp_r       <= exp_nxt;
    base_r      <= base_nxt;
    acc_r       <= acc_nxt;
    plain_r     <= plain_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    chain_value_nxt = chain_value_r;
    chain_sel_nxt   = chain_sel_r;
    blk_nxt         = blk_r;
    red_nxt         = red_r;
    cnt_nxt         = cnt_r;
    exp_nxt         = exp_r;
    base_nxt        = base_r;
    acc_nxt         = acc_r;
    plain_nxt       = plain_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    mm_start        = 1'b0;
    mm_a_acc        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          chain_sel_nxt   = in_req.message_start ? seed_r : chain_value_r;
          chain_value_nxt = in_req.cipher_block;
          blk_nxt         = in_req.cipher_block;
          red_nxt         = '0;
          cnt_nxt         = CW'(VALUE_BITS - 1);
          exp_nxt         = exponent_r;
          acc_nxt         = VALUE_BITS'(1);
          if (modulus_r < VALUE_BITS'(2)) begin
            // arithmetic mod 0 or 1: decrypted value is 0
            acc_nxt   = '0;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_REDUCE;
          end
        end
      end

      ST_REDUCE: begin
        red_nxt = (red_t >= mod_ext) ? VALUE_BITS'(red_t - mod_ext)
                                     : red_t[VALUE_BITS-1:0];
        blk_nxt = {blk_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          base_nxt  = (red_t >= mod_ext) ? VALUE_BITS'(red_t - mod_ext)
                                         : red_t[VALUE_BITS-1:0];
          state_nxt = ST_LOOP;
        end
      end

      ST_LOOP: begin
        if (exp_r == '0) begin
          state_nxt = ST_FINISH;
        end else if (exp_r[0]) begin
          mm_a_acc  = 1'b1;
          mm_start  = 1'b1;
          state_nxt = ST_MUL_ACC;
        end else begin
          exp_nxt   = exp_r >> 1;
          mm_start  = 1'b1;
          state_nxt = ST_MUL_SQR;
        end
      end

      ST_MUL_ACC: begin
        if (mm_stat.done) begin
          acc_nxt = mm_product;
          exp_nxt = exp_r >> 1;
          // no square needed once no higher exponent bit remains
          if (exp_r[VALUE_BITS-1:1] == '0) begin
            state_nxt = ST_FINISH;
          end else begin
            mm_start  = 1'b1;
            state_nxt = ST_MUL_SQR;
          end
        end
      end

      ST_MUL_SQR: begin
        if (mm_stat.done) begin
          base_nxt  = mm_product;
          state_nxt = ST_LOOP;
        end
      end

      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || out_rsp.ready) begin
          plain_nxt     = acc_r ^ chain_sel_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    mm_start |-> !mm_stat.busy)
    else $error("multiplier started while busy");

  a_residues_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOP) |-> (base_r < modulus_r) && (acc_r < modulus_r))
    else $error("residue not below modulus");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !(out_valid_r && !out_rsp.ready)) |-> (state_r == ST_FINISH))
    else $error("result loaded outside FINISH");

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == ST_REDUCE) || (state_r == ST_FINISH))
    else $error("accepted request did not start work");

endmodule

[verif/rsa_cbc_block_decrypt_test.sv]
// Self-checking bench for rsa_cbc_block_decrypt: RSA block decrypt + CBC chain.
// Depends on rcbc_pkg and the rcbc_in_if / rcbc_out_if channel interfaces.
// Queue-fed request driver, result monitor, and a shadow model of the arithmetic.
`timescale 1ns / 1ps

module rsa_cbc_block_decrypt_test;
  import rcbc_pkg::*;

  localparam int W = VALUE_BITS_DEF;
  localparam logic [W-1:0] VALUE_MAX = {W{1'b1}};
  // Index 3 is decoded by nobody; writes to it must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 3000;     // long receiver hold-off
  localparam int unsigned TAIL_CYCLES = 2200;     // > latency of a full exponent
  localparam int unsigned CYCLE_LIMIT = 5000000;  // hang guard

  typedef struct {
    logic [W-1:0] block;
    logic         start;
  } cipher_req_t;

  logic clk;
  logic rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [W-1:0]            cfg_wdata;

  rcbc_in_if  #(.VALUE_BITS(W)) req_if ();
  rcbc_out_if #(.VALUE_BITS(W)) rsp_if ();

  rsa_cbc_block_decrypt #(.VALUE_BITS(W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_if.sink),
    .out_rsp   (rsp_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the block's registers and chain.
  logic [W-1:0] exponent_q;
  logic [W-1:0] modulus_q;
  logic [W-1:0] seed_q;
  logic [W-1:0] chain_q;

  cipher_req_t  cipher_queue[$];    // requests not yet offered
  logic [W-1:0] plain_expected[$];  // predicted results, oldest first
  logic [W-1:0] plain_want;

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned hold_left;
  logic        hold_go;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Right-to-left square-and-multiply; a modulus of 0 or 1 decrypts to 0.
  // Residues are below 2^31, so every product fits in 64 bits.
  function automatic logic [W-1:0] rsa_cbc_plain(logic [W-1:0] blk, logic [W-1:0] chain);
    longint unsigned base;
    longint unsigned acc;
    longint unsigned e;
    longint unsigned m;
    m = 64'(modulus_q);
    acc = 64'd0;
    if (m >= 64'd2) begin
      base = 64'(blk);
      base = base % m;
      acc = 64'd1;
      e = 64'(exponent_q);
      while (e != 64'd0) begin
        if (e[0]) acc = (acc * base) % m;
        base = (base * base) % m;
        e = e >> 1;
      end
    end
    return acc[W-1:0] ^ chain;
  endfunction

  // Mostly full-width values (usually above the modulus), some residues,
  // and the edges around zero, the top value and the modulus.
  function automatic logic [W-1:0] pick_block();
    logic [W-1:0] v;
    v = W'($urandom);
    case ($urandom_range(9))
      0: v = '0;
      1: v = VALUE_MAX;
      2: v = modulus_q - 1'b1;
      3: v = modulus_q;
      4, 5: if (modulus_q >= 2) v = W'($urandom % modulus_q);
      default: ;
    endcase
    return v;
  endfunction

  // Well-formed messages (start, then continuation blocks), with a sprinkle
  // of random start flags to break the chain now and then.
  task automatic queue_messages(int unsigned n);
    int unsigned left;
    int unsigned len;
    cipher_req_t r;
    left = n;
    while (left != 0) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len && left != 0; i++) begin
        r.block = pick_block();
        r.start = (i == 0);
        if ($urandom_range(9) == 0) r.start = 1'($urandom_range(1));
        cipher_queue = {cipher_queue, r};
        left--;
      end
    end
  endtask

  task automatic queue_req(logic [W-1:0] blk, logic start);
    cipher_req_t r;
    r.block = blk;
    r.start = start;
    cipher_queue = {cipher_queue, r};
  endtask

  // Block is idle once everything was offered, taken and answered.
  task automatic drain_requests();
    do @(posedge clk);
    while (cipher_queue.size() != 0 || req_if.valid || plain_expected.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_EXPONENT: exponent_q = val;
      CFG_MODULUS:  modulus_q  = val;
      CFG_SEED:     seed_q     = val;
      default: ;
    endcase
  endtask

  // Request driver: keeps valid up until the request is taken, then
  // maybe idles before offering the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid         <= 1'b0;
      req_if.cipher_block  <= '0;
      req_if.message_start <= 1'b0;
      chain_q = '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        plain_expected = {plain_expected,
                          rsa_cbc_plain(req_if.cipher_block,
                                        req_if.message_start ? seed_q : chain_q)};
        chain_q = req_if.cipher_block;  // raw block, not the residue
      end
      if (!req_if.valid || req_if.ready) begin
        if (cipher_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          req_if.valid         <= 1'b1;
          req_if.cipher_block  <= cipher_queue[0].block;
          req_if.message_start <= cipher_queue[0].start;
          void'(cipher_queue.pop_front());
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each taken result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (plain_expected.size() == 0) begin
          $error("plain_value: none expected, got %h", rsp_if.plain_value);
          mismatch_count++;
        end else begin
          plain_want = plain_expected.pop_front();
          if (rsp_if.plain_value !== plain_want) begin
            $error("plain_value: expected %h, got %h", plain_want, rsp_if.plain_value);
            mismatch_count++;
          end
        end
      end
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Receiver hold-off counter, started by a one-cycle pulse on hold_go.
  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [W-1:0] expo;
    int unsigned nb;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_go = 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    // Register values after reset.
    exponent_q = '0;
    modulus_q = W'(2);
    seed_q = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: exponent 0 mod 2 decrypts to 1. The first request
    // continues a chain that was never started, so it XORs with zero.
    queue_req(W'(32'h1234_5678), 1'b0);
    queue_req(VALUE_MAX, 1'b0);
    queue_req('0, 1'b1);
    queue_req(W'(1), 1'b0);
    drain_requests();

    // All-ones exponent, modulus and seed: slowest path, block == modulus.
    write_reg(CFG_EXPONENT, VALUE_MAX);
    write_reg(CFG_MODULUS, VALUE_MAX);
    write_reg(CFG_SEED, VALUE_MAX);
    queue_req('0, 1'b1);
    queue_req(VALUE_MAX, 1'b0);
    queue_req(W'(32'h2AAA_AAAA), 1'b0);
    queue_req(W'(32'h5555_5555), 1'b1);
    drain_requests();

    // Unused index must be ignored; exponent 0 gives 1 with a big modulus.
    write_reg(CFG_UNUSED, W'(32'h1234));
    write_reg(CFG_EXPONENT, '0);
    queue_req(VALUE_MAX - 1'b1, 1'b1);
    queue_req(W'(3), 1'b0);
    drain_requests();

    // Modulus 0 and 1: decrypted value is 0, result is the chain value.
    write_reg(CFG_EXPONENT, W'(32'h65));
    write_reg(CFG_MODULUS, '0);
    write_reg(CFG_SEED, W'(32'h0F0F_0F0F));
    queue_req(W'(32'h7FFF_0000), 1'b1);
    queue_req(W'(5), 1'b0);
    queue_req('0, 1'b0);
    drain_requests();
    write_reg(CFG_MODULUS, W'(1));
    queue_req(W'(32'h1357_9BDF), 1'b1);
    queue_req(VALUE_MAX, 1'b0);
    drain_requests();

    // Tiny modulus, square of the residue.
    write_reg(CFG_EXPONENT, W'(2));
    write_reg(CFG_MODULUS, W'(3));
    queue_req(W'(2), 1'b1);
    queue_req(W'(4), 1'b0);
    queue_req(W'(3), 1'b1);
    drain_requests();

    // Random part: two settings per idling profile.
    for (int p = 0; p < 8; p++) begin
      case (p / 2)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 45; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 45; end
        default: begin src_idle_pct = 26; snk_stall_pct = 26; end
      endcase
      if (p == 5) begin
        // One setting with a full-width exponent; short ones elsewhere.
        expo = W'($urandom);
        expo[W-1] = 1'b1;
      end else begin
        nb = $urandom_range(1, 8);
        expo = W'($urandom & ((32'd1 << nb) - 1));
        expo[nb-1] = 1'b1;
      end
      write_reg(CFG_EXPONENT, expo);
      if (p == 2) write_reg(CFG_MODULUS, W'($urandom_range(1000, 2)));
      else write_reg(CFG_MODULUS, W'($urandom_range(32'h7FFF_FFFF, 2)));
      write_reg(CFG_SEED, W'($urandom));
      queue_messages(34);
      if (p == 0) begin
        // Stall the result side while requests keep coming, so the output
        // register fills and in_req.ready stays low for a while.
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      drain_requests();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
